// ===== rtl/pieq_pkg.sv =====
// pieq_pkg: shared types, codes and sizing for the pointer input event queue
// no dependencies; every rtl file but pieq_ram takes names from here by scope
`default_nettype none

package pieq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int COORD_W     = 13;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int DROP_W      = 64;
    localparam int CNT_W       = 3;

    localparam logic [COORD_W-1:0] MAX_X_RESET = 13'd1023;
    localparam logic [COORD_W-1:0] MAX_Y_RESET = 13'd767;
    localparam logic [COORD_W-1:0] CUR_X_RESET = MAX_X_RESET / 2;
    localparam logic [COORD_W-1:0] CUR_Y_RESET = MAX_Y_RESET / 2;

    // register index, taken from paddr above the byte offset
    localparam logic [PADDR_W-3:0] REG_MAX_X = 1'd0;
    localparam logic [PADDR_W-3:0] REG_MAX_Y = 1'd1;

    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_MOUSE = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DROP  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [2:0] EV_KEY_DOWN = 3'd0;
    localparam logic [2:0] EV_KEY_UP   = 3'd1;
    localparam logic [2:0] EV_MOVE     = 3'd2;
    localparam logic [2:0] EV_BTN_DOWN = 3'd3;
    localparam logic [2:0] EV_BTN_UP   = 3'd4;
    localparam logic [2:0] EV_WHEEL    = 3'd5;

    // pending event bits, written lowest first
    localparam int MASK_W  = 6;
    localparam int B_MOVE  = 0;
    localparam int B_LEFT  = 1;
    localparam int B_RIGHT = 2;
    localparam int B_MID   = 3;
    localparam int B_WHEEL = 4;
    localparam int B_KEY   = 5;

    typedef struct packed {
        logic [1:0]         op;
        logic               key_pressed;
        logic [7:0]         key_code;
        logic [7:0]         key_char;
        logic [2:0]         modifiers;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic signed [7:0]  wheel;
        logic [2:0]         buttons_now;
        logic [2:0]         buttons_changed;
    } item_t;

    typedef struct packed {
        logic [2:0]         event_type;
        logic [7:0]         event_key;
        logic [7:0]         event_char;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic signed [7:0]  wheel_step;
        logic [2:0]         button_id;
        logic [2:0]         held_buttons;
        logic [2:0]         event_mods;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        logic [MASK_W-1:0]  mask;
        logic [CNT_W-1:0]   count;
        logic               admit;
    } calc_t;

    typedef struct packed {
        entry_t            entry;
        logic [MASK_W-1:0] mask_next;
    } build_t;

endpackage

`default_nettype wire

// ===== rtl/pointer_input_event_queue_unit.sv =====
// Pointer and keyboard event queue. Key items queue one event, mouse items
// move the clamped pointer and queue a batch of up to five events (move,
// left, right, middle, wheel) that is taken whole or dropped whole; pop items
// return the oldest event. One item is in work at a time; the sequencer steps
// from idle to calc, then writes once per queued event or reads once for a
// pop, then goes to done. A dropped item, an item with no event to queue, a
// pop of an empty queue or any other op goes from calc straight to done. The
// steps are set by the event memory, which takes one entry write per cycle and
// returns registered read data. A result waits in the m_ register stage while
// the next item is taken. Uses pieq_pkg, pieq_calc, pieq_build and pieq_ram.
`default_nettype none

module pointer_input_event_queue_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pieq_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [pieq_pkg::PDATA_W-1:0]     pwdata,
    output logic      [pieq_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_op,
    input  wire logic                             s_key_pressed,
    input  wire logic [7:0]                       s_key_code,
    input  wire logic [7:0]                       s_key_char,
    input  wire logic [2:0]                       s_modifiers,
    input  wire logic signed [15:0]               s_delta_x,
    input  wire logic signed [15:0]               s_delta_y,
    input  wire logic signed [7:0]                s_wheel,
    input  wire logic [2:0]                       s_buttons_now,
    input  wire logic [2:0]                       s_buttons_changed,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [1:0]                            m_status,
    output logic [2:0]                            m_event_type,
    output logic [7:0]                            m_event_key,
    output logic [7:0]                            m_event_char,
    output logic [pieq_pkg::COORD_W-1:0]          m_pos_x,
    output logic [pieq_pkg::COORD_W-1:0]          m_pos_y,
    output logic signed [15:0]                    m_move_x,
    output logic signed [15:0]                    m_move_y,
    output logic signed [7:0]                     m_wheel_step,
    output logic [2:0]                            m_button_id,
    output logic [2:0]                            m_held_buttons,
    output logic [2:0]                            m_event_mods
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CALC  = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_READ  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    pieq_pkg::item_t                  item_reg, item_next;
    logic [pieq_pkg::MASK_W-1:0]      mask_reg, mask_next;
    logic [pieq_pkg::IDX_W-1:0]       wr_idx_reg, wr_idx_next;
    logic [pieq_pkg::IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [pieq_pkg::OCC_W-1:0]       occ_reg, occ_next;
    logic [pieq_pkg::DROP_W-1:0]      drop_total_reg, drop_total_next;
    logic [pieq_pkg::COORD_W-1:0]     cursor_x_reg, cursor_x_next;
    logic [pieq_pkg::COORD_W-1:0]     cursor_y_reg, cursor_y_next;
    logic [2:0]                       last_buttons_reg, last_buttons_next;
    logic [pieq_pkg::COORD_W-1:0]     max_x_reg, max_x_next;
    logic [pieq_pkg::COORD_W-1:0]     max_y_reg, max_y_next;
    logic [1:0]                       res_status_reg, res_status_next;
    pieq_pkg::entry_t                 res_entry_reg, res_entry_next;
    logic                             m_valid_reg, m_valid_next;
    logic [1:0]                       m_status_reg, m_status_next;
    pieq_pkg::entry_t                 m_entry_reg, m_entry_next;

    pieq_pkg::calc_t                  calc;
    pieq_pkg::build_t                 build;
    logic                             ram_we;
    logic                             ram_re;
    logic [pieq_pkg::ENTRY_W-1:0]     ram_rdata;
    logic                             cfg_write;
    logic [pieq_pkg::PADDR_W-3:0]     cfg_idx;

    function automatic logic [pieq_pkg::IDX_W-1:0] idx_inc(
        input logic [pieq_pkg::IDX_W-1:0] idx
    );
        logic [pieq_pkg::IDX_W-1:0] r;
        if (idx == pieq_pkg::IDX_W'(pieq_pkg::QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = idx + pieq_pkg::IDX_W'(1);
        end
        return r;
    endfunction

    pieq_calc u_calc (
        .item     (item_reg),
        .cursor_x (cursor_x_reg),
        .cursor_y (cursor_y_reg),
        .max_x    (max_x_reg),
        .max_y    (max_y_reg),
        .occ      (occ_reg),
        .calc     (calc)
    );

    pieq_build u_build (
        .mask         (mask_reg),
        .item         (item_reg),
        .cursor_x     (cursor_x_reg),
        .cursor_y     (cursor_y_reg),
        .last_buttons (last_buttons_reg),
        .build        (build)
    );

    pieq_ram #(
        .WIDTH (pieq_pkg::ENTRY_W),
        .DEPTH (pieq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (build.entry),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // configuration port
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[pieq_pkg::PADDR_W-1:2];
    assign pready    = 1'b1;

    always_comb begin
        if (cfg_idx == pieq_pkg::REG_MAX_Y) begin
            prdata = {{(pieq_pkg::PDATA_W - pieq_pkg::COORD_W){1'b0}}, max_y_reg};
        end else begin
            prdata = {{(pieq_pkg::PDATA_W - pieq_pkg::COORD_W){1'b0}}, max_x_reg};
        end
    end

    always_comb begin
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        if (cfg_write) begin
            if (cfg_idx == pieq_pkg::REG_MAX_X) begin
                max_x_next = pwdata[pieq_pkg::COORD_W-1:0];
            end else begin
                max_y_next = pwdata[pieq_pkg::COORD_W-1:0];
            end
        end
    end

    // item sequencer
    always_comb begin
        state_next        = state_reg;
        item_next         = item_reg;
        mask_next         = mask_reg;
        wr_idx_next       = wr_idx_reg;
        rd_idx_next       = rd_idx_reg;
        occ_next          = occ_reg;
        drop_total_next   = drop_total_reg;
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        last_buttons_next = last_buttons_reg;
        res_status_next   = res_status_reg;
        res_entry_next    = res_entry_reg;
        m_valid_next      = m_valid_reg;
        m_status_next     = m_status_reg;
        m_entry_next      = m_entry_reg;
        ram_we            = 1'b0;
        ram_re            = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next.op              = s_op;
                    item_next.key_pressed     = s_key_pressed;
                    item_next.key_code        = s_key_code;
                    item_next.key_char        = s_key_char;
                    item_next.modifiers       = s_modifiers;
                    item_next.delta_x         = s_delta_x;
                    item_next.delta_y         = s_delta_y;
                    item_next.wheel           = s_wheel;
                    item_next.buttons_now     = s_buttons_now;
                    item_next.buttons_changed = s_buttons_changed;
                    state_next                = ST_CALC;
                end
            end
            ST_CALC: begin
                res_entry_next  = '0;
                res_status_next = pieq_pkg::STAT_OK;
                state_next      = ST_DONE;
                case (item_reg.op)
                    pieq_pkg::OP_KEY, pieq_pkg::OP_MOUSE: begin
                        if (calc.admit) begin
                            mask_next = calc.mask;
                            if (item_reg.op == pieq_pkg::OP_MOUSE) begin
                                cursor_x_next     = calc.nx;
                                cursor_y_next     = calc.ny;
                                last_buttons_next = item_reg.buttons_now;
                            end
                            if (calc.mask != '0) begin
                                state_next = ST_WRITE;
                            end
                        end else begin
                            drop_total_next = drop_total_reg
                                            + pieq_pkg::DROP_W'(calc.count);
                            res_status_next = pieq_pkg::STAT_DROP;
                        end
                    end
                    pieq_pkg::OP_POP: begin
                        if (occ_reg == '0) begin
                            res_status_next = pieq_pkg::STAT_EMPTY;
                        end else begin
                            ram_re      = 1'b1;
                            rd_idx_next = idx_inc(rd_idx_reg);
                            occ_next    = occ_reg - pieq_pkg::OCC_W'(1);
                            state_next  = ST_READ;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WRITE: begin
                ram_we      = 1'b1;
                wr_idx_next = idx_inc(wr_idx_reg);
                occ_next    = occ_reg + pieq_pkg::OCC_W'(1);
                mask_next   = build.mask_next;
                if (build.mask_next == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                res_entry_next = pieq_pkg::entry_t'(ram_rdata);
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_entry_next  = res_entry_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            mask_reg         <= '0;
            wr_idx_reg       <= '0;
            rd_idx_reg       <= '0;
            occ_reg          <= '0;
            drop_total_reg   <= '0;
            cursor_x_reg     <= pieq_pkg::CUR_X_RESET;
            cursor_y_reg     <= pieq_pkg::CUR_Y_RESET;
            last_buttons_reg <= '0;
            max_x_reg        <= pieq_pkg::MAX_X_RESET;
            max_y_reg        <= pieq_pkg::MAX_Y_RESET;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            mask_reg         <= mask_next;
            wr_idx_reg       <= wr_idx_next;
            rd_idx_reg       <= rd_idx_next;
            occ_reg          <= occ_next;
            drop_total_reg   <= drop_total_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            last_buttons_reg <= last_buttons_next;
            max_x_reg        <= max_x_next;
            max_y_reg        <= max_y_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        m_status_reg   <= m_status_next;
        m_entry_reg    <= m_entry_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_event_type   = m_entry_reg.event_type;
    assign m_event_key    = m_entry_reg.event_key;
    assign m_event_char   = m_entry_reg.event_char;
    assign m_pos_x        = m_entry_reg.pos_x;
    assign m_pos_y        = m_entry_reg.pos_y;
    assign m_move_x       = m_entry_reg.move_x;
    assign m_move_y       = m_entry_reg.move_y;
    assign m_wheel_step   = m_entry_reg.wheel_step;
    assign m_button_id    = m_entry_reg.button_id;
    assign m_held_buttons = m_entry_reg.held_buttons;
    assign m_event_mods   = m_entry_reg.event_mods;

endmodule

`default_nettype wire

// ===== rtl/pieq_ram.sv =====
// pieq_ram: generic single-write, single-read synchronous memory
// registered read data; no package dependency
`default_nettype none

module pieq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/pieq_calc.sv =====
// pieq_calc: pointer clamp, event batch mask and free space check for one item
// depends on pieq_pkg
`default_nettype none

module pieq_calc (
    input  wire pieq_pkg::item_t                 item,
    input  wire logic [pieq_pkg::COORD_W-1:0]    cursor_x,
    input  wire logic [pieq_pkg::COORD_W-1:0]    cursor_y,
    input  wire logic [pieq_pkg::COORD_W-1:0]    max_x,
    input  wire logic [pieq_pkg::COORD_W-1:0]    max_y,
    input  wire logic [pieq_pkg::OCC_W-1:0]      occ,
    output pieq_pkg::calc_t                      calc
);

    logic signed [17:0]                  sum_x;
    logic signed [17:0]                  sum_y;
    logic [pieq_pkg::COORD_W-1:0]        nx;
    logic [pieq_pkg::COORD_W-1:0]        ny;
    logic                                moved;
    logic [pieq_pkg::MASK_W-1:0]         mask;
    logic [pieq_pkg::CNT_W-1:0]          count;
    logic [pieq_pkg::OCC_W-1:0]          free;

    always_comb begin
        sum_x = $signed({5'b00000, cursor_x})
              + $signed({{2{item.delta_x[15]}}, item.delta_x});
        sum_y = $signed({5'b00000, cursor_y})
              + $signed({{2{item.delta_y[15]}}, item.delta_y});

        if (sum_x[17]) begin
            nx = '0;
        end else if (sum_x > $signed({5'b00000, max_x})) begin
            nx = max_x;
        end else begin
            nx = sum_x[pieq_pkg::COORD_W-1:0];
        end

        if (sum_y[17]) begin
            ny = '0;
        end else if (sum_y > $signed({5'b00000, max_y})) begin
            ny = max_y;
        end else begin
            ny = sum_y[pieq_pkg::COORD_W-1:0];
        end

        moved = (nx != cursor_x) || (ny != cursor_y);

        mask = '0;
        case (item.op)
            pieq_pkg::OP_KEY: begin
                mask[pieq_pkg::B_KEY] = 1'b1;
            end
            pieq_pkg::OP_MOUSE: begin
                mask[pieq_pkg::B_MOVE]  = moved;
                mask[pieq_pkg::B_LEFT]  = item.buttons_changed[0];
                mask[pieq_pkg::B_RIGHT] = item.buttons_changed[1];
                mask[pieq_pkg::B_MID]   = item.buttons_changed[2];
                mask[pieq_pkg::B_WHEEL] = (item.wheel != 8'sd0);
            end
            default: begin
                mask = '0;
            end
        endcase

        count = pieq_pkg::CNT_W'($countones(mask));
        free  = pieq_pkg::OCC_W'(pieq_pkg::QUEUE_DEPTH) - occ;

        calc.nx    = nx;
        calc.ny    = ny;
        calc.mask  = mask;
        calc.count = count;
        calc.admit = (pieq_pkg::OCC_W'(count) <= free);
    end

endmodule

`default_nettype wire

// ===== rtl/pieq_build.sv =====
// pieq_build: forms the queue entry for the lowest pending event bit
// depends on pieq_pkg
`default_nettype none

module pieq_build (
    input  wire logic [pieq_pkg::MASK_W-1:0]  mask,
    input  wire pieq_pkg::item_t              item,
    input  wire logic [pieq_pkg::COORD_W-1:0] cursor_x,
    input  wire logic [pieq_pkg::COORD_W-1:0] cursor_y,
    input  wire logic [2:0]                   last_buttons,
    output pieq_pkg::build_t                  build
);

    logic [pieq_pkg::MASK_W-1:0] lowest;
    pieq_pkg::entry_t            entry;

    always_comb begin
        lowest = mask & (~mask + pieq_pkg::MASK_W'(1));

        entry              = '0;
        entry.pos_x        = cursor_x;
        entry.pos_y        = cursor_y;
        entry.held_buttons = item.buttons_now;

        if (lowest[pieq_pkg::B_KEY]) begin
            entry.event_type   = item.key_pressed ? pieq_pkg::EV_KEY_DOWN
                                                  : pieq_pkg::EV_KEY_UP;
            entry.event_key    = item.key_code;
            entry.event_char   = item.key_char;
            entry.event_mods   = item.modifiers;
            entry.held_buttons = last_buttons;
        end else if (lowest[pieq_pkg::B_MOVE]) begin
            entry.event_type = pieq_pkg::EV_MOVE;
            entry.move_x     = item.delta_x;
            entry.move_y     = item.delta_y;
        end else if (lowest[pieq_pkg::B_LEFT]) begin
            entry.event_type = item.buttons_now[0] ? pieq_pkg::EV_BTN_DOWN
                                                   : pieq_pkg::EV_BTN_UP;
            entry.button_id  = 3'b001;
        end else if (lowest[pieq_pkg::B_RIGHT]) begin
            entry.event_type = item.buttons_now[1] ? pieq_pkg::EV_BTN_DOWN
                                                   : pieq_pkg::EV_BTN_UP;
            entry.button_id  = 3'b010;
        end else if (lowest[pieq_pkg::B_MID]) begin
            entry.event_type = item.buttons_now[2] ? pieq_pkg::EV_BTN_DOWN
                                                   : pieq_pkg::EV_BTN_UP;
            entry.button_id  = 3'b100;
        end else begin
            entry.event_type = pieq_pkg::EV_WHEEL;
            entry.wheel_step = item.wheel;
        end

        build.entry     = entry;
        build.mask_next = mask & ~lowest;
    end

endmodule

`default_nettype wire

// ===== rtl/pieq_checker.sv =====
// pieq_props: port-level checks for pointer_input_event_queue_unit
// depends on pieq_pkg; bound to the top level at the end of this file
`default_nettype none

module pieq_props (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [1:0]                    m_status,
    input wire logic [2:0]                    m_event_type,
    input wire logic [pieq_pkg::COORD_W-1:0]  m_pos_x,
    input wire logic [pieq_pkg::COORD_W-1:0]  m_pos_y,
    input wire logic [2:0]                    m_held_buttons
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result stays valid with the same status and event type
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_event_type))
        else $error("stalled result changed");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken in back to back cycles");

    // drop and empty results carry no event
    a_status_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == pieq_pkg::STAT_DROP || m_status == pieq_pkg::STAT_EMPTY)
        |-> m_event_type == 3'd0 && m_pos_x == '0 && m_pos_y == '0
            && m_held_buttons == 3'd0)
        else $error("non-event result carries event fields");

endmodule

bind pointer_input_event_queue_unit pieq_props u_pieq_props (.*);

`default_nettype wire
